// ===== src/interval_range_assign_table_defines.svh =====
// Assertion macros used by the controller RTL (irat_ctrl).
`ifndef INTERVAL_RANGE_ASSIGN_TABLE_DEFINES_SVH
`define INTERVAL_RANGE_ASSIGN_TABLE_DEFINES_SVH

// Checks a property on every rising clock edge outside reset.
`define IRAT_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("irat assertion failed");

// Checks that a signal holds its value into the next cycle when a condition holds.
`define IRAT_ASSERT_HOLD(lbl, cond, sig) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> $stable(sig)) \
    else $error("irat hold assertion failed");

`endif

// ===== src/irat_pkg.sv =====
`timescale 1ns / 1ps
package irat_pkg;

  localparam int unsigned DEF_TABLE_DEPTH = 64;
  localparam int unsigned DEF_KEY_WIDTH   = 32;
  localparam int unsigned DEF_VALUE_WIDTH = 8;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic {
    FUNC_ASSIGN = 1'b0,
    FUNC_LOOKUP = 1'b1
  } func_t;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_SCAN  = 6'b000010,
    S_MOVE  = 6'b000100,
    S_INS_B = 6'b001000,
    S_INS_E = 6'b010000,
    S_DONE  = 6'b100000
  } state_t;

endpackage

// ===== src/irat_mem.sv =====
`timescale 1ns / 1ps
module irat_mem #(
  parameter int unsigned TABLE_DEPTH = irat_pkg::DEF_TABLE_DEPTH,
  parameter int unsigned KEY_WIDTH   = irat_pkg::DEF_KEY_WIDTH,
  parameter int unsigned VALUE_WIDTH = irat_pkg::DEF_VALUE_WIDTH,
  parameter int unsigned AW          = $clog2(TABLE_DEPTH)
) (
  input  logic                   clk,
  input  logic                   we,
  input  logic [AW-1:0]          waddr,
  input  logic [KEY_WIDTH-1:0]   wkey,
  input  logic [VALUE_WIDTH-1:0] wval,
  input  logic                   re,
  input  logic [AW-1:0]          raddr,
  output logic [KEY_WIDTH-1:0]   rkey,
  output logic [VALUE_WIDTH-1:0] rval
);
  import irat_pkg::*;

  logic [KEY_WIDTH-1:0]   key_mem [TABLE_DEPTH];
  logic [VALUE_WIDTH-1:0] val_mem [TABLE_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      key_mem[waddr] <= wkey;
      val_mem[waddr] <= wval;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rkey <= key_mem[raddr];
      rval <= val_mem[raddr];
    end
  end

endmodule

// ===== src/irat_ctrl.sv =====
`timescale 1ns / 1ps
module irat_ctrl #(
  parameter int unsigned TABLE_DEPTH = irat_pkg::DEF_TABLE_DEPTH,
  parameter int unsigned KEY_WIDTH   = irat_pkg::DEF_KEY_WIDTH,
  parameter int unsigned VALUE_WIDTH = irat_pkg::DEF_VALUE_WIDTH,
  parameter int unsigned AW          = $clog2(TABLE_DEPTH),
  parameter int unsigned CW          = $clog2(TABLE_DEPTH + 1)
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic [VALUE_WIDTH-1:0] default_value,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic                   in_func,
  input  logic [KEY_WIDTH-1:0]   in_key_begin,
  input  logic [KEY_WIDTH-1:0]   in_key_end,
  input  logic [VALUE_WIDTH-1:0] in_new_value,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [VALUE_WIDTH-1:0] out_read_value,
  output irat_pkg::status_t      out_status,
  output logic [CW-1:0]          out_entry_count,
  output logic                   mem_we,
  output logic [AW-1:0]          mem_waddr,
  output logic [KEY_WIDTH-1:0]   mem_wkey,
  output logic [VALUE_WIDTH-1:0] mem_wval,
  output logic                   mem_re,
  output logic [AW-1:0]          mem_raddr,
  input  logic [KEY_WIDTH-1:0]   mem_rkey,
  input  logic [VALUE_WIDTH-1:0] mem_rval
);
  import irat_pkg::*;

  localparam logic [KEY_WIDTH-1:0] KEY_SIGN = {1'b1, {(KEY_WIDTH-1){1'b0}}};

  state_t state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [CW-1:0] iss_r, iss_nxt;
  logic dv_r, dv_nxt;
  logic func_r, func_nxt;
  logic [KEY_WIDTH-1:0] b_r, b_nxt, e_r, e_nxt;
  logic [VALUE_WIDTH-1:0] v_r, v_nxt;
  logic [CW-1:0] p_r, p_nxt, q_r, q_nxt;
  logic [VALUE_WIDTH-1:0] before_r, before_nxt, at_end_r, at_end_nxt;
  logic up_r, up_nxt;
  logic [CW-1:0] dist_r, dist_nxt;
  logic [CW-1:0] src_r, src_nxt, rem_r, rem_nxt;
  logic pend_r, pend_nxt;
  logic [AW-1:0] pend_addr_r, pend_addr_nxt;
  logic out_valid_r, out_valid_nxt;
  logic [VALUE_WIDTH-1:0] res_val_r, res_val_nxt;
  status_t res_st_r, res_st_nxt;
  logic [VALUE_WIDTH-1:0] out_val_r, out_val_nxt;
  status_t out_st_r, out_st_nxt;
  logic [CW-1:0] out_cnt_r, out_cnt_nxt;

  logic keep_b, keep_e;
  logic [CW:0] w_cnt;
  logic [CW+1:0] total;
  logic [CW-1:0] tgt;
  logic [KEY_WIDTH-1:0] kb_ord, ke_ord;

  assign kb_ord = in_key_begin ^ KEY_SIGN;
  assign ke_ord = in_key_end ^ KEY_SIGN;
  assign keep_b = (v_r != before_r);
  assign keep_e = (at_end_r != v_r);
  assign w_cnt = {1'b0, p_r} + (CW + 1)'(keep_b) + (CW + 1)'(keep_e);
  assign total = {1'b0, w_cnt} + (CW + 2)'(cnt_r) - (CW + 2)'(q_r);
  assign tgt = up_r ? src_r + dist_r : src_r - dist_r;

  assign in_ready = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_read_value = out_val_r;
  assign out_status = out_st_r;
  assign out_entry_count = out_cnt_r;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt = cnt_r;
    iss_nxt = iss_r;
    dv_nxt = 1'b0;
    func_nxt = func_r;
    b_nxt = b_r;
    e_nxt = e_r;
    v_nxt = v_r;
    p_nxt = p_r;
    q_nxt = q_r;
    before_nxt = before_r;
    at_end_nxt = at_end_r;
    up_nxt = up_r;
    dist_nxt = dist_r;
    src_nxt = src_r;
    rem_nxt = rem_r;
    pend_nxt = 1'b0;
    pend_addr_nxt = pend_addr_r;
    out_valid_nxt = out_valid_r && !out_ready;
    res_val_nxt = res_val_r;
    res_st_nxt = res_st_r;
    out_val_nxt = out_val_r;
    out_st_nxt = out_st_r;
    out_cnt_nxt = out_cnt_r;
    mem_we = 1'b0;
    mem_waddr = pend_addr_r;
    mem_wkey = mem_rkey;
    mem_wval = mem_rval;
    mem_re = 1'b0;
    mem_raddr = iss_r[AW-1:0];

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          func_nxt = in_func;
          b_nxt = kb_ord;
          e_nxt = (in_func == FUNC_LOOKUP) ? kb_ord : ke_ord;
          v_nxt = in_new_value;
          iss_nxt = '0;
          p_nxt = '0;
          q_nxt = '0;
          before_nxt = default_value;
          at_end_nxt = default_value;
          if (in_func == FUNC_ASSIGN && !(kb_ord < ke_ord)) begin
            res_val_nxt = '0;
            res_st_nxt = ST_EMPTY;
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (iss_r != cnt_r) begin
          mem_re = 1'b1;
          iss_nxt = iss_r + 1'b1;
          dv_nxt = 1'b1;
        end
        if (dv_r) begin
          if (mem_rkey < b_r) begin
            p_nxt = p_r + 1'b1;
            before_nxt = mem_rval;
          end
          if (mem_rkey <= e_r) begin
            q_nxt = q_r + 1'b1;
            at_end_nxt = mem_rval;
          end
        end else if (iss_r == cnt_r) begin
          if (func_r == FUNC_LOOKUP) begin
            res_val_nxt = at_end_r;
            res_st_nxt = ST_DONE;
            state_nxt = S_DONE;
          end else if (total > (CW + 2)'(TABLE_DEPTH)) begin
            res_val_nxt = '0;
            res_st_nxt = ST_FULL;
            state_nxt = S_DONE;
          end else begin
            up_nxt = (w_cnt > {1'b0, q_r});
            dist_nxt = (w_cnt > {1'b0, q_r}) ? CW'(w_cnt - {1'b0, q_r})
                                             : CW'({1'b0, q_r} - w_cnt);
            rem_nxt = cnt_r - q_r;
            src_nxt = (w_cnt > {1'b0, q_r}) ? cnt_r - 1'b1 : q_r;
            state_nxt = S_MOVE;
          end
        end
      end
      S_MOVE: begin
        mem_raddr = src_r[AW-1:0];
        mem_we = pend_r;
        if (rem_r != '0 && dist_r != '0) begin
          mem_re = 1'b1;
          src_nxt = up_r ? src_r - 1'b1 : src_r + 1'b1;
          rem_nxt = rem_r - 1'b1;
          pend_nxt = 1'b1;
          pend_addr_nxt = tgt[AW-1:0];
        end else if (!pend_r) begin
          state_nxt = S_INS_B;
        end
      end
      S_INS_B: begin
        mem_we = keep_b;
        mem_waddr = p_r[AW-1:0];
        mem_wkey = b_r;
        mem_wval = v_r;
        state_nxt = S_INS_E;
      end
      S_INS_E: begin
        mem_we = keep_e;
        mem_waddr = AW'(p_r + CW'(keep_b));
        mem_wkey = e_r;
        mem_wval = at_end_r;
        cnt_nxt = total[CW-1:0];
        res_val_nxt = '0;
        res_st_nxt = ST_DONE;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_val_nxt = res_val_r;
          out_st_nxt = res_st_r;
          out_cnt_nxt = cnt_r;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r <= '0;
      dv_r <= 1'b0;
      pend_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r <= cnt_nxt;
      dv_r <= dv_nxt;
      pend_r <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    iss_r <= iss_nxt;
    func_r <= func_nxt;
    b_r <= b_nxt;
    e_r <= e_nxt;
    v_r <= v_nxt;
    p_r <= p_nxt;
    q_r <= q_nxt;
    before_r <= before_nxt;
    at_end_r <= at_end_nxt;
    up_r <= up_nxt;
    dist_r <= dist_nxt;
    src_r <= src_nxt;
    rem_r <= rem_nxt;
    pend_addr_r <= pend_addr_nxt;
    res_val_r <= res_val_nxt;
    res_st_r <= res_st_nxt;
    out_val_r <= out_val_nxt;
    out_st_r <= out_st_nxt;
    out_cnt_r <= out_cnt_nxt;
  end

`include "interval_range_assign_table_defines.svh"

  `IRAT_ASSERT(a_cnt_bound, cnt_r <= CW'(TABLE_DEPTH))
  `IRAT_ASSERT(a_no_write_in_scan, state_r == S_SCAN |-> !mem_we)
  `IRAT_ASSERT(a_pend_in_move, pend_r |-> state_r == S_MOVE)
  `IRAT_ASSERT_HOLD(a_cnt_only_at_commit, state_r != S_INS_E, cnt_r)

endmodule

// ===== src/interval_range_assign_table.sv =====
`timescale 1ns / 1ps
// Interval table with range assign and point lookup.
// Input channel (in_valid/in_ready): in_func selects an assign of in_new_value
// over [in_key_begin, in_key_end) or a lookup at in_key_begin; keys are signed.
// Result channel (out_valid/out_ready): one transfer per input item with
// out_read_value, out_status and out_entry_count.
// The APB port at cfg_ holds default_value at address 0; write it only while idle.
// An item starts with a scan that reads the table memory one entry per cycle
// over the current breakpoints. An assign may add a pass that shifts entries
// through the same memory port; an empty range skips the scan and goes
// straight to the result.
// One item is worked on at a time; the next is taken once the result sits in
// the output register, even while the receiver stalls it. A stalled result
// holds until taken and blocks only the next item's completion.
// Reset clears the breakpoint count and default_value; the table memory needs
// no clearing pass.
module interval_range_assign_table #(
  parameter int unsigned TABLE_DEPTH = irat_pkg::DEF_TABLE_DEPTH,
  parameter int unsigned KEY_WIDTH   = irat_pkg::DEF_KEY_WIDTH,
  parameter int unsigned VALUE_WIDTH = irat_pkg::DEF_VALUE_WIDTH,
  parameter int unsigned DW          = (VALUE_WIDTH > 32) ? 64 : 32,
  parameter int unsigned PAW         = $clog2(DW / 8),
  parameter int unsigned CW          = $clog2(TABLE_DEPTH + 1)
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic                   in_func,
  input  logic [KEY_WIDTH-1:0]   in_key_begin,
  input  logic [KEY_WIDTH-1:0]   in_key_end,
  input  logic [VALUE_WIDTH-1:0] in_new_value,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [VALUE_WIDTH-1:0] out_read_value,
  output logic [1:0]             out_status,
  output logic [CW-1:0]          out_entry_count,
  input  logic                   cfg_psel,
  input  logic                   cfg_penable,
  input  logic                   cfg_pwrite,
  input  logic [PAW-1:0]         cfg_paddr,
  input  logic [DW-1:0]          cfg_pwdata,
  output logic [DW-1:0]          cfg_prdata,
  output logic                   cfg_pready
);
  import irat_pkg::*;

  localparam int unsigned AW = $clog2(TABLE_DEPTH);

  logic [VALUE_WIDTH-1:0] default_value_r;
  status_t st;
  logic mem_we, mem_re;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [KEY_WIDTH-1:0] mem_wkey, mem_rkey;
  logic [VALUE_WIDTH-1:0] mem_wval, mem_rval;

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr == '0) ? DW'(default_value_r) : '0;
  assign out_status = st;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      default_value_r <= '0;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
      default_value_r <= cfg_pwdata[VALUE_WIDTH-1:0];
    end
  end

  irat_mem #(
    .TABLE_DEPTH(TABLE_DEPTH),
    .KEY_WIDTH  (KEY_WIDTH),
    .VALUE_WIDTH(VALUE_WIDTH),
    .AW         (AW)
  ) u_mem (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wkey (mem_wkey),
    .wval (mem_wval),
    .re   (mem_re),
    .raddr(mem_raddr),
    .rkey (mem_rkey),
    .rval (mem_rval)
  );

  irat_ctrl #(
    .TABLE_DEPTH(TABLE_DEPTH),
    .KEY_WIDTH  (KEY_WIDTH),
    .VALUE_WIDTH(VALUE_WIDTH),
    .AW         (AW),
    .CW         (CW)
  ) u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .default_value  (default_value_r),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_func        (in_func),
    .in_key_begin   (in_key_begin),
    .in_key_end     (in_key_end),
    .in_new_value   (in_new_value),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_read_value (out_read_value),
    .out_status     (st),
    .out_entry_count(out_entry_count),
    .mem_we         (mem_we),
    .mem_waddr      (mem_waddr),
    .mem_wkey       (mem_wkey),
    .mem_wval       (mem_wval),
    .mem_re         (mem_re),
    .mem_raddr      (mem_raddr),
    .mem_rkey       (mem_rkey),
    .mem_rval       (mem_rval)
  );

endmodule
